@@ rtl/core/filmic_tone_curve_rgb_assert.svh @@
// Assertion macros for the filmic tone curve core.
// Define ASSERT_OFF to compile the checks away.
`ifndef FILMIC_TONE_CURVE_RGB_ASSERT_SVH
`define FILMIC_TONE_CURVE_RGB_ASSERT_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define FTC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ftc: property violated");
// expr must never be true outside reset
`define FTC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ftc: forbidden condition seen");
`else
`define FTC_ASSERT(label, clk, rst_n, prop)
`define FTC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

@@ rtl/core/ftc_pkg.sv @@
// Shared constants and types of the filmic tone curve core.
// No dependencies.
package ftc_pkg;

    localparam int LANES           = 3;
    localparam int IN_W            = 24;
    localparam int INPUT_FRAC_BITS = 16;
    localparam int GAIN_W          = 16;
    localparam int GAIN_FRAC       = 8;
    localparam int OUTPUT_BITS     = 16;
    localparam int OUT_W           = OUTPUT_BITS;

    localparam int PROD_W   = IN_W + GAIN_W;
    localparam int SQ_W     = 2 * IN_W;
    // 620*x^2 + 170*2^F*x + 6*2^2F stays below 796*2^(2*IN_W)
    localparam int DEN_W    = 2 * IN_W + 10;
    localparam int QUO_BITS = OUTPUT_BITS + 1;
    // scale (2) + polynomial (2) + divider steps + rounding
    localparam int PIPE_LAT = QUO_BITS + 5;

    localparam logic [IN_W-1:0]   IN_MAX     = '1;
    localparam logic [IN_W-1:0]   BLACK_CODE =
        IN_W'(((4 << INPUT_FRAC_BITS) + 500) / 1000);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << GAIN_FRAC);

    // curve coefficients scaled by 100
    localparam logic [DEN_W-1:0] K_SQ    = DEN_W'(620);
    localparam logic [DEN_W-1:0] K_NUM_X = DEN_W'(50) << INPUT_FRAC_BITS;
    localparam logic [DEN_W-1:0] K_DEN_X = DEN_W'(170) << INPUT_FRAC_BITS;
    localparam logic [DEN_W-1:0] K_DEN_C = DEN_W'(6) << (2 * INPUT_FRAC_BITS);

    typedef struct packed {
        logic [IN_W-1:0] red_in;
        logic [IN_W-1:0] green_in;
        logic [IN_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
    } t_pix_out;

    typedef logic [LANES-1:0][IN_W-1:0]  t_lane_x;
    typedef logic [LANES-1:0][DEN_W-1:0] t_lane_wide;
    typedef logic [LANES-1:0][OUT_W-1:0] t_lane_out;

endpackage

@@ rtl/core/ftc_scale.sv @@
// Exposure multiply, saturation and black offset, two stages.
// Depends on ftc_pkg and the assertion macro header.
`include "filmic_tone_curve_rgb_assert.svh"

module ftc_scale
    import ftc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_lane_x           i_lin,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_vld,
    output t_lane_x           o_x
);

    logic [LANES-1:0][PROD_W-1:0] r_prod;
    logic                         r_vld_a;
    t_lane_x                      r_x;
    t_lane_x                      n_x;
    logic                         r_vld_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_prod[l] <= PROD_W'(i_lin[l]) * PROD_W'(i_gain);
        end
        r_x <= n_x;
    end

    always_comb begin
        logic [IN_W-1:0] sat;
        for (int l = 0; l < LANES; l++) begin
            if (|r_prod[l][PROD_W-1:GAIN_FRAC+IN_W]) begin
                sat = IN_MAX;
            end else begin
                sat = r_prod[l][GAIN_FRAC +: IN_W];
            end
            n_x[l] = (sat > BLACK_CODE) ? sat - BLACK_CODE : '0;
        end
    end

    assign o_vld = r_vld_b;
    assign o_x   = r_x;

    for (genvar l = 0; l < LANES; l++) begin : g_chk
        `FTC_ASSERT(a_x_range, i_clk, i_rst_n, r_vld_b |-> (r_x[l] <= IN_MAX - BLACK_CODE))
    end

endmodule

@@ rtl/core/ftc_poly.sv @@
// Numerator and denominator of the film curve, two stages.
// Depends on ftc_pkg.
module ftc_poly
    import ftc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_lane_x    i_x,
    output logic       o_vld,
    output t_lane_wide o_num,
    output t_lane_wide o_den
);

    logic [LANES-1:0][SQ_W-1:0] r_sq;
    t_lane_x                    r_x;
    logic                       r_vld_c;
    t_lane_wide                 r_num;
    t_lane_wide                 r_den;
    logic                       r_vld_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            r_vld_c <= i_vld;
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_sq[l]  <= SQ_W'(i_x[l]) * SQ_W'(i_x[l]);
            r_x[l]   <= i_x[l];
            // constant coefficients only: shift-add networks
            r_num[l] <= K_SQ * DEN_W'(r_sq[l]) + K_NUM_X * DEN_W'(r_x[l]);
            r_den[l] <= K_SQ * DEN_W'(r_sq[l]) + K_DEN_X * DEN_W'(r_x[l]) + K_DEN_C;
        end
    end

    assign o_vld = r_vld_d;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

@@ rtl/core/ftc_div.sv @@
// Restoring divider, one quotient bit per stage, then round and clamp.
// Depends on ftc_pkg and the assertion macro header.
`include "filmic_tone_curve_rgb_assert.svh"

module ftc_div
    import ftc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_lane_wide i_num,
    input  t_lane_wide i_den,
    output logic       o_vld,
    output t_lane_out  o_y
);

    t_lane_wide                     r_rem [QUO_BITS];
    t_lane_wide                     r_den [QUO_BITS];
    logic [LANES-1:0][QUO_BITS-1:0] r_q   [QUO_BITS];
    logic [QUO_BITS-1:0]            r_vld;
    t_lane_out                      r_y;
    t_lane_out                      n_y;
    logic                           r_out_vld;

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        t_lane_wide                     src_rem;
        t_lane_wide                     src_den;
        logic [LANES-1:0][QUO_BITS-1:0] src_q;
        logic                           src_vld;
        t_lane_wide                     n_rem;
        logic [LANES-1:0][QUO_BITS-1:0] n_q;

        if (k == 0) begin : g_first
            assign src_rem = i_num;
            assign src_den = i_den;
            assign src_q   = '0;
            assign src_vld = i_vld;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_den = r_den[k-1];
            assign src_q   = r_q[k-1];
            assign src_vld = r_vld[k-1];
        end

        always_comb begin
            logic [DEN_W:0] shifted;
            for (int l = 0; l < LANES; l++) begin
                shifted = {src_rem[l], 1'b0};
                if (shifted >= {1'b0, src_den[l]}) begin
                    n_rem[l] = DEN_W'(shifted - {1'b0, src_den[l]});
                    n_q[l]   = {src_q[l][QUO_BITS-2:0], 1'b1};
                end else begin
                    n_rem[l] = shifted[DEN_W-1:0];
                    n_q[l]   = {src_q[l][QUO_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_den[k] <= src_den;
            r_q[k]   <= n_q;
        end
    end

    // one extra fraction bit, round half up, clamp at all ones
    always_comb begin
        logic [QUO_BITS:0] rnd;
        for (int l = 0; l < LANES; l++) begin
            rnd = {1'b0, r_q[QUO_BITS-1][l]} + (QUO_BITS+1)'(1);
            if (rnd[QUO_BITS]) begin
                n_y[l] = '1;
            end else begin
                n_y[l] = rnd[QUO_BITS-1:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[QUO_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_vld = r_out_vld;
    assign o_y   = r_y;

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_chk
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            `FTC_ASSERT(a_rem_below_den, i_clk, i_rst_n, r_vld[k] |-> (r_rem[k][l] < r_den[k][l]))
        end
    end

endmodule

@@ rtl/core/filmic_tone_curve_rgb.sv @@
// Top level of the filmic tone curve core: exposure register and lane pipeline.
// Depends on ftc_pkg, ftc_scale, ftc_poly, ftc_div and the assertion macro header.
//
//  channel   ports                          direction  handshake
//  pixel in  start, busy, i_pix             in         start & !busy
//  result    o_result_valid, o_pix          out        one-cycle strobe
//  config    i_cfg_we, i_cfg_wdata          in         write enable
//
// One pixel per clock; busy is always low. The pipeline registers exposure and black
// offset, then the curve polynomials, then each quotient bit of the 17-stage divider,
// then the rounded result. Synchronous active-low reset clears the valid pipe and
// sets the exposure gain to 1.0. The receiver cannot stall.
`include "filmic_tone_curve_rgb_assert.svh"

module filmic_tone_curve_rgb
    import ftc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_pix_in           i_pix,
    output logic              o_result_valid,
    output t_pix_out          o_pix,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_wdata
);

    logic [GAIN_W-1:0] r_gain;
    logic              accept;
    t_lane_x           lin;
    logic              x_vld;
    t_lane_x           x;
    logic              pq_vld;
    t_lane_wide        num;
    t_lane_wide        den;
    logic              y_vld;
    t_lane_out         y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign lin[0] = i_pix.red_in;
    assign lin[1] = i_pix.green_in;
    assign lin[2] = i_pix.blue_in;

    ftc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_lin   (lin),
        .i_gain  (r_gain),
        .o_vld   (x_vld),
        .o_x     (x)
    );

    ftc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (x_vld),
        .i_x     (x),
        .o_vld   (pq_vld),
        .o_num   (num),
        .o_den   (den)
    );

    ftc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (pq_vld),
        .i_num   (num),
        .i_den   (den),
        .o_vld   (y_vld),
        .o_y     (y)
    );

    assign o_result_valid  = y_vld;
    assign o_pix.red_out   = y[0];
    assign o_pix.green_out = y[1];
    assign o_pix.blue_out  = y[2];

    `FTC_ASSERT(a_result_from_item, i_clk, i_rst_n, o_result_valid |-> $past(accept, PIPE_LAT))

endmodule

@@ tb/filmic_tone_curve_rgb_test.sv @@
// Self-checking bench for filmic_tone_curve_rgb: exposure scaling, black offset and curve per lane.
// A directed table runs first, then random pixels under many exposure gains.
// Depends on ftc_pkg and the filmic_tone_curve_rgb RTL.
module filmic_tone_curve_rgb_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ftc_pkg::*;

    typedef enum logic {ROW_PIXEL, ROW_GAIN} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [GAIN_W-1:0] gain;
        logic [IN_W-1:0]   r;
        logic [IN_W-1:0]   g;
        logic [IN_W-1:0]   b;
        logic              known;
        logic [OUT_W-1:0]  er;
        logic [OUT_W-1:0]  eg;
        logic [OUT_W-1:0]  eb;
    } t_stim_row;

    localparam int DIR_ROWS     = 20;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 112;
    localparam int IDLE_PERCENT = 32;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_pix_in           i_pix       = '0;
    logic              o_result_valid;
    t_pix_out          o_pix;
    logic              i_cfg_we    = 1'b0;
    logic [GAIN_W-1:0] i_cfg_wdata = '0;

    // expected pixels, oldest first
    t_pix_out          tone_expected[$];
    logic [GAIN_W-1:0] gain_shadow = GAIN_RESET;
    bit                idle_on     = 1'b1;
    int                errors      = 0;
    int                items_sent  = 0;
    int                pixels_seen = 0;
    int                gains_set   = 0;
    t_pix_out          want;
    t_lane_out         want_l;
    t_lane_out         got_l;
    string             lane_name[LANES] = '{"blue", "green", "red"};

    t_stim_row dir_table[DIR_ROWS] = '{
        '{ROW_PIXEL, 16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 16'h0, 16'h0, 16'h0},
        // at and just below the black offset
        '{ROW_PIXEL, 16'h0000, 24'h000106, 24'h000105, 24'h000001, 1'b1, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h000107, 24'h010000, 24'hFFFFFF, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h800000, 24'h7FFFFF, 24'h555555, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'hAAAAAA, 24'h0000FF, 24'h00FFFF, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_GAIN,  16'hFFFF, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0, 16'h0, 16'h0},
        // exposure product saturates
        '{ROW_PIXEL, 16'h0000, 24'hFFFFFF, 24'h010000, 24'h000001, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h000106, 24'h000107, 24'h000200, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_GAIN,  16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'h0, 16'h0, 16'h0},
        '{ROW_GAIN,  16'h0001, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'hFFFFFF, 24'h010600, 24'h010700, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_GAIN,  16'h8000, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h020000, 24'h000003, 24'h0000FF, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_GAIN,  16'h0080, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h00020C, 24'h00020D, 24'hFFFFFF, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_GAIN,  16'h0100, 24'h000000, 24'h000000, 24'h000000, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h0F0F0F, 24'hF0F0F0, 24'h123456, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 16'h0, 16'h0, 16'h0}
    };

    filmic_tone_curve_rgb uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pix          (i_pix),
        .o_result_valid (o_result_valid),
        .o_pix          (o_pix),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one lane: exposure, black offset, rational curve by long division, round half up
    function automatic logic [OUT_W-1:0] tone_lane(logic [IN_W-1:0] chan,
                                                   logic [GAIN_W-1:0] gain);
        logic [63:0] unit;
        logic [63:0] scaled;
        logic [63:0] x;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] full;
        unit   = 64'd1 << INPUT_FRAC_BITS;
        full   = (64'd1 << OUTPUT_BITS) - 64'd1;
        scaled = (64'(chan) * 64'(gain)) >> GAIN_FRAC;
        if (scaled > 64'(IN_MAX)) begin
            scaled = 64'(IN_MAX);
        end
        x   = (scaled > 64'(BLACK_CODE)) ? scaled - 64'(BLACK_CODE) : 64'd0;
        num = x * (64'd620 * x + 64'd50 * unit);
        den = x * (64'd620 * x + 64'd170 * unit) + 64'd6 * unit * unit;
        rem = num;
        q   = '0;
        for (int i = 0; i < OUTPUT_BITS + 1; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 64'd1;
            end
        end
        q = (q + 64'd1) >> 1;
        if (q > full) begin
            q = full;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic t_pix_out tone_pixel(t_pix_in p, logic [GAIN_W-1:0] gain);
        t_pix_out o;
        o.red_out   = tone_lane(p.red_in, gain);
        o.green_out = tone_lane(p.green_in, gain);
        o.blue_out  = tone_lane(p.blue_in, gain);
        return o;
    endfunction

    // channel values spread over dark, around 1.0, log-spread, uniform and near max
    function automatic logic [IN_W-1:0] rand_chan();
        case ($urandom_range(5))
            0: return IN_W'($urandom_range(600));
            1: return IN_W'($urandom_range(32'h30000));
            2, 3: return IN_W'($urandom);
            4: return IN_W'($urandom >> $urandom_range(31));
            default: return IN_MAX - IN_W'($urandom_range(3));
        endcase
    endfunction

    task automatic send_pixel(t_pix_in p, t_pix_out exp_pix);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_pix <= p;
        do @(posedge i_clk); while (busy);
        tone_expected.push_back(exp_pix);
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (tone_expected.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] gain);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gain;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gain_shadow = gain;
        gains_set++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (tone_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual %h", $time, o_pix);
            end else begin
                want   = tone_expected.pop_front();
                want_l = want;
                got_l  = o_pix;
                pixels_seen++;
                for (int l = LANES - 1; l >= 0; l--) begin
                    if (got_l[l] !== want_l[l]) begin
                        errors++;
                        $display("%0t: %s mismatch, expected %h, actual %h",
                                 $time, lane_name[l], want_l[l], got_l[l]);
                    end
                end
            end
        end
    end

    initial begin
        t_pix_in           p;
        t_pix_out          e;
        logic [GAIN_W-1:0] g;
        logic [GAIN_W-1:0] fixed_gains[6];
        fixed_gains = '{16'h0100, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0040};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_GAIN) begin
                wait_drained();
                write_gain(dir_table[r].gain);
            end else begin
                p = '{dir_table[r].r, dir_table[r].g, dir_table[r].b};
                if (dir_table[r].known) begin
                    e = '{dir_table[r].er, dir_table[r].eg, dir_table[r].eb};
                end else begin
                    e = tone_pixel(p, gain_shadow);
                end
                send_pixel(p, e);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 6) begin
                g = fixed_gains[ph];
            end else if (ph % 2 == 0) begin
                g = GAIN_W'($urandom_range(16'hFFFF));
            end else begin
                g = GAIN_W'($urandom_range(16'hFFFF) >> $urandom_range(8));
            end
            // the sender holds off here until every outstanding item has come back
            wait_drained();
            write_gain(g);
            idle_on = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                p = '{rand_chan(), rand_chan(), rand_chan()};
                send_pixel(p, tone_pixel(p, gain_shadow));
            end
        end

        wait_drained();
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        $display("sent %0d pixels (%0d directed rows), checked %0d results",
                 items_sent, DIR_ROWS, pixels_seen);
        $display("exposure gains written: %0d, including 0, 1/256, 1.0, 128.0 and max",
                 gains_set);
        if (errors == 0 && tone_expected.size() == 0) begin
            $display("filmic_tone_curve_rgb_test: done, clean");
        end else begin
            $display("filmic_tone_curve_rgb_test: done, errors");
        end
        $finish;
    end

    initial begin
        #500us;
        $display("timeout: %0d results still outstanding", tone_expected.size());
        $display("filmic_tone_curve_rgb_test: done, errors");
        $finish;
    end

endmodule
